@@ hdl/battery_pack_monitor_top_macros.svh @@
// Assertion macros of the battery pack monitor top level.
`ifndef BATTERY_PACK_MONITOR_TOP_MACROS_SVH
`define BATTERY_PACK_MONITOR_TOP_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define BPM_NEVER(lbl, cond, msg) \
  `BPM_ASSERT(lbl, !(cond), msg)

`endif

@@ hdl/bpm_pkg.sv @@
// Types, constants and codes of the battery pack monitor.
`default_nettype none
package bpm_pkg;

  localparam int RAW_W     = 12;
  localparam int GAIN_W    = 20;
  localparam int ALPHA_W   = 17;
  localparam int CNT_W     = 4;
  localparam int MV_W      = 16;
  localparam int Q_W       = 32;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int LIM_W     = MV_W + CNT_W;

  localparam int DEF_MAX_CELLS = 8;
  localparam int DEF_ADC_BITS  = 12;

  localparam logic [GAIN_W-1:0]  GAIN_RST    = 20'd580900;
  localparam logic [ALPHA_W-1:0] ALPHA_RST   = 17'd6554;
  localparam logic [CNT_W-1:0]   FIXED_RST   = 4'd0;
  localparam logic [MV_W-1:0]    PRESENT_RST = 16'd3000;
  localparam logic [MV_W-1:0]    CELLMAX_RST = 16'd4350;
  localparam logic [MV_W-1:0]    WARN_RST    = 16'd3500;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
  localparam logic [Q_W-1:0]     MV_SAT    = 32'hFFFF0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN    = 3'd0,
    REG_ALPHA   = 3'd1,
    REG_FIXED   = 3'd2,
    REG_PRESENT = 3'd3,
    REG_CELLMAX = 3'd4,
    REG_WARN    = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_DIFF,
    S_MUL,
    S_ADD,
    S_CELLS,
    S_DETECT,
    S_PREP,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [MV_W-1:0]  dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [MV_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/battery_pack_monitor_top.sv @@
// Top level of the battery pack monitor: sequencer, filter datapath and outputs.
// The block takes one raw ADC sample per request on the input channel
// (in_valid_i / in_ready_o / sample_raw_i) and returns one result per request
// on the output channel (out_valid_o / out_ready_i and the result fields).
// A sample is scaled to millivolts by a Q4.16 gain, saturated at 65535 mV and
// smoothed by an exponential moving average; the first sample seeds the filter.
// The cell count is fixed by configuration or detected once and then held while the pack stays present.
// Work on a request runs through a small sequencer: scale (one multiply),
// filter (difference, multiply, add), cell decision, a detection loop of one
// compare per candidate count, and a 16-step restoring divider for the
// per-cell voltage. One request is worked on at a time, and in_ready_o is
// high only while the sequencer is idle.
// A finished result waits in the output register; while the receiver stalls,
// the next request is still accepted and worked on, and it waits in its last
// step until the output register is free.
// Reset clears the filter, the seed flag, the held cell count and the output
// valid, and loads the configuration registers with their defaults. The
// configuration port writes one register per enabled cycle, with no wait.
`default_nettype none
`include "battery_pack_monitor_top_macros.svh"
module battery_pack_monitor_top #(
  parameter int MAX_CELLS = bpm_pkg::DEF_MAX_CELLS,
  parameter int ADC_BITS  = bpm_pkg::DEF_ADC_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bpm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [bpm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bpm_pkg::RAW_W-1:0]     sample_raw_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [bpm_pkg::MV_W-1:0]           pack_mv_o,
  output logic [bpm_pkg::CNT_W-1:0]          cell_count_o,
  output logic [bpm_pkg::MV_W-1:0]           per_cell_mv_o,
  output logic                               pack_present_o,
  output logic                               voltage_low_o
);

  localparam int RAW_W = bpm_pkg::RAW_W;
  localparam int CNT_W = bpm_pkg::CNT_W;
  localparam int MV_W  = bpm_pkg::MV_W;
  localparam int Q_W   = bpm_pkg::Q_W;
  localparam int LIM_W = bpm_pkg::LIM_W;
  localparam int PROD_W = Q_W + MV_W;

  // The cell count port holds at most 15 cells.
  localparam logic [CNT_W-1:0] CELL_CAP = (MAX_CELLS > 15) ? 4'd15 : CNT_W'(MAX_CELLS);
  // Only the low ADC_BITS bits of a sample carry the reading.
  localparam logic [RAW_W-1:0] ADC_MASK =
      (ADC_BITS >= RAW_W) ? {RAW_W{1'b1}} : RAW_W'((1 << ADC_BITS) - 1);

  // Configuration registers.
  logic [bpm_pkg::GAIN_W-1:0]  gain_q;
  logic [bpm_pkg::ALPHA_W-1:0] alpha_q;
  logic [CNT_W-1:0]            fixed_q;
  logic [MV_W-1:0]             present_q, cellmax_q, warn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= bpm_pkg::GAIN_RST;
      alpha_q   <= bpm_pkg::ALPHA_RST;
      fixed_q   <= bpm_pkg::FIXED_RST;
      present_q <= bpm_pkg::PRESENT_RST;
      cellmax_q <= bpm_pkg::CELLMAX_RST;
      warn_q    <= bpm_pkg::WARN_RST;
    end else if (cfg_we_i) begin
      unique case (bpm_pkg::reg_idx_e'(cfg_idx_i))
        bpm_pkg::REG_GAIN:    gain_q    <= cfg_wdata_i[bpm_pkg::GAIN_W-1:0];
        bpm_pkg::REG_ALPHA:   alpha_q   <= cfg_wdata_i[bpm_pkg::ALPHA_W-1:0];
        bpm_pkg::REG_FIXED:   fixed_q   <= cfg_wdata_i[CNT_W-1:0];
        bpm_pkg::REG_PRESENT: present_q <= cfg_wdata_i[MV_W-1:0];
        bpm_pkg::REG_CELLMAX: cellmax_q <= cfg_wdata_i[MV_W-1:0];
        bpm_pkg::REG_WARN:    warn_q    <= cfg_wdata_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state.
  bpm_pkg::state_e state_q, state_d;
  logic              seeded_q, seeded_d;
  logic [Q_W-1:0]    filt_q, filt_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic              out_valid_q, out_valid_d;

  logic [RAW_W-1:0]  raw_q, raw_d;
  logic [Q_W-1:0]    v_q, v_d;
  logic [Q_W-1:0]    diff_q, diff_d;
  logic              up_q, up_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [CNT_W-1:0]  cand_q, cand_d;
  logic [LIM_W-1:0]  lim_q, lim_d;
  logic              low_q, low_d;

  logic [MV_W-1:0]   pack_mv_q, pack_mv_d, per_cell_q, per_cell_d;
  logic [CNT_W-1:0]  cells_out_q, cells_out_d;
  logic              present_out_q, present_out_d, low_out_q, low_out_d;

  bpm_pkg::div_req_t div_req;
  bpm_pkg::div_rsp_t div_rsp;

  // Arithmetic of the individual steps.
  logic [Q_W-1:0]              scaled;
  logic [bpm_pkg::ALPHA_W-1:0] alpha_c;
  logic [Q_W-1:0]              step_mv;
  logic                        above_present;
  logic                        fits_cand;
  logic [CNT_W-1:0]            fixed_c;
  logic [LIM_W-1:0]            warn_lim;

  assign scaled  = Q_W'(raw_q & ADC_MASK) * Q_W'(gain_q);
  assign alpha_c = (alpha_q > bpm_pkg::ALPHA_ONE) ? bpm_pkg::ALPHA_ONE : alpha_q;
  assign step_mv = prod_q[PROD_W-1:MV_W];
  assign above_present = filt_q >= {present_q, 16'h0000};
  assign fits_cand = {{CNT_W{1'b0}}, filt_q} <= {lim_q, 16'h0000};
  assign fixed_c  = (fixed_q > CELL_CAP) ? CELL_CAP : fixed_q;
  assign warn_lim = LIM_W'(warn_q) * LIM_W'(held_q);

  bpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpm_pkg::S_IDLE;
      seeded_q    <= 1'b0;
      filt_q      <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seeded_q    <= seeded_d;
      filt_q      <= filt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q         <= raw_d;
    v_q           <= v_d;
    diff_q        <= diff_d;
    up_q          <= up_d;
    prod_q        <= prod_d;
    cand_q        <= cand_d;
    lim_q         <= lim_d;
    low_q         <= low_d;
    pack_mv_q     <= pack_mv_d;
    per_cell_q    <= per_cell_d;
    cells_out_q   <= cells_out_d;
    present_out_q <= present_out_d;
    low_out_q     <= low_out_d;
  end

  always_comb begin
    state_d       = state_q;
    seeded_d      = seeded_q;
    filt_d        = filt_q;
    held_d        = held_q;
    raw_d         = raw_q;
    v_d           = v_q;
    diff_d        = diff_q;
    up_d          = up_q;
    prod_d        = prod_q;
    cand_d        = cand_q;
    lim_d         = lim_q;
    low_d         = low_q;
    pack_mv_d     = pack_mv_q;
    per_cell_d    = per_cell_q;
    cells_out_d   = cells_out_q;
    present_out_d = present_out_q;
    low_out_d     = low_out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    in_ready_o    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = filt_q[Q_W-1:MV_W];
    div_req.divisor  = held_q;

    unique case (state_q)
      bpm_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          raw_d   = sample_raw_i;
          state_d = bpm_pkg::S_SCALE;
        end
      end
      bpm_pkg::S_SCALE: begin
        v_d = (scaled > bpm_pkg::MV_SAT) ? bpm_pkg::MV_SAT : scaled;
        if (seeded_q) begin
          state_d = bpm_pkg::S_DIFF;
        end else begin
          // The first sample after reset loads the filter directly.
          filt_d   = v_d;
          seeded_d = 1'b1;
          state_d  = bpm_pkg::S_CELLS;
        end
      end
      bpm_pkg::S_DIFF: begin
        up_d    = v_q >= filt_q;
        diff_d  = up_d ? (v_q - filt_q) : (filt_q - v_q);
        state_d = bpm_pkg::S_MUL;
      end
      bpm_pkg::S_MUL: begin
        prod_d  = PROD_W'(alpha_c) * PROD_W'(diff_q);
        state_d = bpm_pkg::S_ADD;
      end
      bpm_pkg::S_ADD: begin
        // The step never exceeds the difference, so the sum stays in range.
        filt_d  = up_q ? (filt_q + step_mv) : (filt_q - step_mv);
        state_d = bpm_pkg::S_CELLS;
      end
      bpm_pkg::S_CELLS: begin
        state_d = bpm_pkg::S_PREP;
        if (fixed_q != '0) begin
          held_d = above_present ? fixed_c : '0;
        end else if (!above_present) begin
          held_d = '0;
        end else if (held_q == '0) begin
          cand_d  = CNT_W'(1);
          lim_d   = LIM_W'(cellmax_q);
          state_d = bpm_pkg::S_DETECT;
        end
      end
      bpm_pkg::S_DETECT: begin
        // One candidate count per cycle, stopping at the first count that fits or at the cap.
        if (fits_cand || cand_q == CELL_CAP) begin
          held_d  = cand_q;
          state_d = bpm_pkg::S_PREP;
        end else begin
          cand_d = cand_q + 1'b1;
          lim_d  = lim_q + LIM_W'(cellmax_q);
        end
      end
      bpm_pkg::S_PREP: begin
        low_d = (held_q != '0) && ({{CNT_W{1'b0}}, filt_q} < {warn_lim, 16'h0000});
        if (held_q != '0) begin
          div_req.start = 1'b1;
          state_d       = bpm_pkg::S_DIV;
        end else begin
          state_d = bpm_pkg::S_DONE;
        end
      end
      bpm_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_d = bpm_pkg::S_DONE;
        end
      end
      bpm_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          pack_mv_d     = filt_q[Q_W-1:MV_W];
          cells_out_d   = held_q;
          per_cell_d    = (held_q != '0) ? div_rsp.quotient : '0;
          present_out_d = held_q != '0;
          low_out_d     = low_q;
          out_valid_d   = 1'b1;
          state_d       = bpm_pkg::S_IDLE;
        end
      end
      default: state_d = bpm_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign pack_mv_o      = pack_mv_q;
  assign cell_count_o   = cells_out_q;
  assign per_cell_mv_o  = per_cell_q;
  assign pack_present_o = present_out_q;
  assign voltage_low_o  = low_out_q;

  `BPM_ASSERT(a_filter_seeded, state_q == bpm_pkg::S_DIFF |-> seeded_q, "filter step before seed")
  `BPM_NEVER(a_held_cap, held_q > CELL_CAP, "held cell count above cap")
  `BPM_ASSERT(a_present_match, out_valid_o |-> pack_present_o == (cell_count_o != '0), "present flag mismatch")
  `BPM_ASSERT(a_low_needs_pack, out_valid_o && voltage_low_o |-> pack_present_o, "low flag without pack")
  `BPM_ASSERT(a_div_bound, out_valid_o && pack_present_o |-> (20'(per_cell_mv_o) * 20'(cell_count_o)) <= 20'(pack_mv_o), "per-cell value too large")

endmodule
`default_nettype wire

@@ hdl/bpm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-cell voltage.
`default_nettype none
module bpm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bpm_pkg::div_req_t req_i,
  output bpm_pkg::div_rsp_t      rsp_o
);

  localparam int STEP_W = $clog2(bpm_pkg::MV_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(bpm_pkg::MV_W - 1);

  logic                      busy_q, done_q;
  logic [STEP_W-1:0]         step_q;
  logic [bpm_pkg::MV_W-1:0]  quo_q;
  logic [bpm_pkg::CNT_W-1:0] rem_q, div_q;
  logic [bpm_pkg::CNT_W:0]   rem_sh;
  logic                      fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_q, quo_q[bpm_pkg::MV_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      if (step_q == STEP_LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
      step_q <= step_q + 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= bpm_pkg::CNT_W'(rem_sh - {1'b0, div_q});
      end else begin
        rem_q <= rem_sh[bpm_pkg::CNT_W-1:0];
      end
      quo_q <= {quo_q[bpm_pkg::MV_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
`default_nettype wire
